@@ hdl/calendar_time_advance_unit_defines.svh @@
// Assertion macros shared by the calendar time advance RTL.
`ifndef CALENDAR_TIME_ADVANCE_UNIT_DEFINES_SVH
`define CALENDAR_TIME_ADVANCE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar time advance: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar time advance: next-cycle check failed");

`endif

@@ hdl/cta_pkg.sv @@
// Package: payload and stage types, constants and month length table.
package cta_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;

    // Opcodes
    localparam logic [1:0] OP_ADD_MIN  = 2'd0;
    localparam logic [1:0] OP_ADD_FIVE = 2'd1;
    localparam logic [1:0] OP_ADD_HOUR = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
    // Five-minute add carries into the hour from this minute upward
    localparam logic [MINUTE_W-1:0] FIVE_WRAP   = 6'd55;
    localparam logic [MINUTE_W-1:0] FIVE_STEP   = 6'd5;
    // Five-minute add starting at or past the last minute ends here
    localparam logic [MINUTE_W-1:0] FIVE_FROM_TOP = 6'd4;
    localparam logic [HOUR_W:0]     HOUR_LAST   = 6'd23;
    localparam logic [MONTH_W:0]    MONTH_LAST  = 5'd12;
    localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_APR   = 4'd4;
    localparam logic [MONTH_W-1:0]  MONTH_JUN   = 4'd6;
    localparam logic [MONTH_W-1:0]  MONTH_SEP   = 4'd9;
    localparam logic [MONTH_W-1:0]  MONTH_NOV   = 4'd11;

    // y / 25 == (y * RECIP_25) >> RECIP_SHIFT, exact for all 14-bit y
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [DAY_W-1:0] DIV_25 = 5'd25;

    typedef struct packed {
        logic [1:0]          op;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } in_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   next_year;
        logic [MONTH_W-1:0]  next_month;
        logic [DAY_W-1:0]    next_day;
        logic [HOUR_W-1:0]   next_hour;
        logic [MINUTE_W-1:0] next_minute;
    } out_item_t;

    // After the minute stage
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                hour_step;
        logic [PROD_W-1:0]   year_prod;
    } min_stage_t;

    // After the hour stage
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                day_carry;
        logic                leap;
    } hour_stage_t;

    // Days in month; out-of-range months count as 31 days
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/calendar_time_advance_unit.sv @@
// Each item passes the minute, hour/leap and date stage registers in that order to the output.
// Throughput: one item per cycle while out_ready is high; stages minute -> hour/leap -> date each hold one item.
// Ready runs back combinationally through the stages, so a stall loses nothing.
// Reset (rst_n low, async): all stage valid bits clear, pipeline empty; data regs
// keep their contents, no clearing pass.
`include "calendar_time_advance_unit_defines.svh"

module calendar_time_advance_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cta_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output cta_pkg::out_item_t  out_item
);

    // stage 1 -> stage 2
    logic                  min_valid;
    logic                  min_ready;
    cta_pkg::min_stage_t   min_item;
    // stage 2 -> stage 3
    logic                  hour_valid;
    logic                  hour_ready;
    cta_pkg::hour_stage_t  hour_item;

    // Stage 1: minute add (1, 5 or 0 minutes); at most one carry into the hour
    // results for any op, so a single hour-step flag travels on. The year
    // is multiplied by the reciprocal of 25 here for the leap test.
    cta_minute_stage u_minute (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (min_valid),
        .out_ready (min_ready),
        .out_item  (min_item)
    );

    // Stage 2: hour step, producing the day carry, and the leap bit from the
    // quotient (year mod 25 via one multiply-subtract).
    cta_hour_stage u_hour (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (min_valid),
        .in_ready  (min_ready),
        .in_item   (min_item),
        .out_valid (hour_valid),
        .out_ready (hour_ready),
        .out_item  (hour_item)
    );

    // Stage 3: month length lookup, day/month/year carry; its register is
    // the output register, and while a result waits there the next item stays in the hour stage.
    cta_date_stage u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hour_valid),
        .in_ready  (hour_ready),
        .in_item   (hour_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // input can only be refused when every stage is full and the output stalls
    `CTA_ASSERT_NOW(a_refuse_only_full, !in_ready, out_valid && !out_ready && min_valid && hour_valid)
    // the hour stage, holding an item that it cannot pass on, keeps it
    `CTA_ASSERT_NEXT(a_hour_hold, hour_valid && !hour_ready, hour_valid && $stable(hour_item))

endmodule

@@ hdl/cta_minute_stage.sv @@
// Stage 1: minute step, hour-step flag, year reciprocal product.
module cta_minute_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cta_pkg::in_item_t     in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cta_pkg::min_stage_t   out_item
);

    logic                 valid_reg;
    cta_pkg::min_stage_t  data_reg;
    cta_pkg::min_stage_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = data_reg;

    always_comb
    begin
        data_next.year      = in_item.year;
        data_next.month     = in_item.month;
        data_next.day       = in_item.day;
        data_next.hour      = in_item.hour;
        data_next.minute    = in_item.minute;
        data_next.hour_step = 1'b0;
        data_next.year_prod = cta_pkg::PROD_W'(in_item.year) *
                              cta_pkg::PROD_W'(cta_pkg::RECIP_25);
        unique case (in_item.op)
            cta_pkg::OP_ADD_MIN:
            begin
                if (in_item.minute >= cta_pkg::MINUTE_LAST)
                begin
                    data_next.minute    = '0;
                    data_next.hour_step = 1'b1;
                end
                else
                begin
                    data_next.minute = in_item.minute + 6'd1;
                end
            end
            cta_pkg::OP_ADD_FIVE:
            begin
                // at most one carry across the five single steps
                if (in_item.minute >= cta_pkg::MINUTE_LAST)
                begin
                    data_next.minute    = cta_pkg::FIVE_FROM_TOP;
                    data_next.hour_step = 1'b1;
                end
                else if (in_item.minute >= cta_pkg::FIVE_WRAP)
                begin
                    data_next.minute    = in_item.minute - cta_pkg::FIVE_WRAP;
                    data_next.hour_step = 1'b1;
                end
                else
                begin
                    data_next.minute = in_item.minute + cta_pkg::FIVE_STEP;
                end
            end
            cta_pkg::OP_ADD_HOUR:
            begin
                data_next.hour_step = 1'b1;
            end
            default:
            begin
                data_next.hour_step = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hdl/cta_hour_stage.sv @@
// Stage 2: hour step with day carry, leap-year decision.
`include "calendar_time_advance_unit_defines.svh"

module cta_hour_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cta_pkg::min_stage_t    in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cta_pkg::hour_stage_t   out_item
);

    logic                      valid_reg;
    cta_pkg::hour_stage_t      data_reg;
    cta_pkg::hour_stage_t      data_next;
    logic [cta_pkg::HOUR_W:0]  hour_inc;
    logic [cta_pkg::QUOT_W-1:0] quot;
    logic [cta_pkg::YEAR_W:0]  rem;
    logic                      div25;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = data_reg;

    always_comb
    begin
        hour_inc = {1'b0, in_item.hour} + 6'd1;
        quot     = in_item.year_prod[cta_pkg::PROD_W-1:cta_pkg::RECIP_SHIFT];
        rem      = {1'b0, in_item.year} -
                   ((cta_pkg::YEAR_W+1)'(quot) * (cta_pkg::YEAR_W+1)'(cta_pkg::DIV_25));
        div25    = (rem == '0);

        data_next.year      = in_item.year;
        data_next.month     = in_item.month;
        data_next.day       = in_item.day;
        data_next.hour      = in_item.hour;
        data_next.minute    = in_item.minute;
        data_next.day_carry = 1'b0;
        // leap: /4 and not /100, or /400  ==  /4 and (not /25 or /16)
        data_next.leap      = (in_item.year[1:0] == 2'b00) &&
                              (!div25 || (in_item.year[3:0] == 4'b0000));
        if (in_item.hour_step)
        begin
            if (hour_inc > cta_pkg::HOUR_LAST)
            begin
                data_next.hour      = '0;
                data_next.day_carry = 1'b1;
            end
            else
            begin
                data_next.hour = hour_inc[cta_pkg::HOUR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    // a day carry only leaves midnight behind it
    `CTA_ASSERT_NOW(a_carry_at_midnight, valid_reg && data_reg.day_carry, data_reg.hour == '0)

endmodule

@@ hdl/cta_date_stage.sv @@
// Stage 3: day, month and year carry; output register.
`include "calendar_time_advance_unit_defines.svh"

module cta_date_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cta_pkg::hour_stage_t   in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cta_pkg::out_item_t     out_item
);

    logic                        valid_reg;
    cta_pkg::out_item_t          data_reg;
    cta_pkg::out_item_t          data_next;
    logic [cta_pkg::DAY_W-1:0]   len;
    logic [cta_pkg::DAY_W:0]     day_inc;
    logic [cta_pkg::MONTH_W:0]   month_inc;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = data_reg;

    always_comb
    begin
        len       = cta_pkg::month_len(in_item.leap, in_item.month);
        day_inc   = {1'b0, in_item.day} + 6'd1;
        month_inc = {1'b0, in_item.month} + 5'd1;

        data_next.next_year   = in_item.year;
        data_next.next_month  = in_item.month;
        data_next.next_day    = in_item.day;
        data_next.next_hour   = in_item.hour;
        data_next.next_minute = in_item.minute;
        if (in_item.day_carry)
        begin
            if (day_inc > {1'b0, len})
            begin
                data_next.next_day = 5'd1;
                if (month_inc > cta_pkg::MONTH_LAST)
                begin
                    data_next.next_month = 4'd1;
                    data_next.next_year  = in_item.year + 14'd1;
                end
                else
                begin
                    data_next.next_month = month_inc[cta_pkg::MONTH_W-1:0];
                end
            end
            else
            begin
                data_next.next_day = day_inc[cta_pkg::DAY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    // end of a common-year February rolls into March
    `CTA_ASSERT_NEXT(a_feb_end, in_valid && in_ready && in_item.day_carry && !in_item.leap && in_item.month == cta_pkg::MONTH_FEB && in_item.day == 5'd28, data_reg.next_day == 5'd1 && data_reg.next_month == 4'd3)

endmodule
